// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the rotator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/evr_pkg.sv =====
// ----------------------------------------------------------------------------
// evr_pkg
// Widths, constants and helper functions of the Euler vertex rotator.
// ----------------------------------------------------------------------------
package evr_pkg;

   // Vertex and coefficient formats
   localparam int COORD_WIDTH    = 32;
   localparam int COEF_FRAC_BITS = 16;
   localparam int COEF_WIDTH     = COEF_FRAC_BITS + 2;
   localparam int DATA_WIDTH     = ((3 * COORD_WIDTH + 7) / 8) * 8;

   // Configuration port
   localparam int ANGLE_WIDTH = 16;
   localparam int CSR_ADDR_W  = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PITCH = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_YAW   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROLL  = 2'd2;

   // Trig and CORDIC formats
   localparam int TRIG_FRAC    = 30;
   localparam int TRIG_WIDTH   = 32;
   localparam int CORDIC_XW    = 34;
   localparam int CORDIC_ZW    = 32;
   localparam int CORDIC_STEPS = 20;
   localparam int STEP_W       = 5;
   localparam int ANGLE_SHIFT  = 14;
   localparam int RED_W        = 18;
   localparam int T_W          = 13;
   localparam int FULL_TURN    = 23040;
   localparam int QUARTER_TURN = 5760;
   localparam int CORDIC_START = 652032874;

   typedef logic signed [COEF_WIDTH-1:0]  coef_type;
   typedef logic signed [TRIG_WIDTH-1:0]  trig_type;
   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   // Arctangent of 2^-i in units of 2^-20 degree
   function automatic logic signed [CORDIC_ZW-1:0] atan_unit(input logic [STEP_W-1:0] i);
      logic signed [CORDIC_ZW-1:0] a;
      case (i)
         5'd0:    a = 32'sd47185920;
         5'd1:    a = 32'sd27855475;
         5'd2:    a = 32'sd14718068;
         5'd3:    a = 32'sd7471121;
         5'd4:    a = 32'sd3750058;
         5'd5:    a = 32'sd1876857;
         5'd6:    a = 32'sd938658;
         5'd7:    a = 32'sd469357;
         5'd8:    a = 32'sd234682;
         5'd9:    a = 32'sd117342;
         5'd10:   a = 32'sd58671;
         5'd11:   a = 32'sd29335;
         5'd12:   a = 32'sd14668;
         5'd13:   a = 32'sd7334;
         5'd14:   a = 32'sd3667;
         5'd15:   a = 32'sd1833;
         5'd16:   a = 32'sd917;
         5'd17:   a = 32'sd458;
         5'd18:   a = 32'sd229;
         5'd19:   a = 32'sd115;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ===== hdl/evr_coef.sv =====
// ----------------------------------------------------------------------------
// evr_coef
// Angle registers and rotation matrix builder: CORDIC per angle, one shared
// multiplier for the trig products, then rounding into the coefficient file.
// ----------------------------------------------------------------------------
module evr_coef import evr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [ANGLE_WIDTH-1:0] csr_wdata,
   output coef_type               coef [9],
   output logic                   busy
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SETUP, ST_ROTATE, ST_FINISH, ST_MULT, ST_STORE
   } state_type;

   localparam int MULW = 2 * TRIG_WIDTH;
   localparam int SUMW = TRIG_WIDTH + 2;
   localparam int CSHIFT = TRIG_FRAC - COEF_FRAC_BITS;
   localparam logic signed [MULW-1:0] MUL_HALF = MULW'(1) << (TRIG_FRAC - 1);
   localparam logic signed [SUMW-1:0] CHALF = SUMW'((64'sd1 <<< CSHIFT) >>> 1);
   localparam logic signed [SUMW-1:0] CMAX = SUMW'((64'sd1 <<< (COEF_FRAC_BITS + 1)) - 1);
   localparam logic signed [SUMW-1:0] CMIN = -CMAX - SUMW'(1);
   localparam logic signed [RED_W-1:0] FT = RED_W'(FULL_TURN);
   localparam logic signed [RED_W-1:0] QT = RED_W'(QUARTER_TURN);

   state_type state_ff;
   logic [ANGLE_WIDTH-1:0] pitch_ff, yaw_ff, roll_ff;
   logic [1:0] sel_ff;
   logic [STEP_W-1:0] step_ff;
   logic [3:0] k_ff;
   logic [1:0] quad_ff;
   logic signed [CORDIC_XW-1:0] x_ff, y_ff;
   logic signed [CORDIC_ZW-1:0] z_ff;
   trig_type trig_ff [6];
   trig_type prod_ff [14];
   logic signed [MULW-1:0] mul_ff, mul_in;
   logic [3:0] mul_idx_ff;
   logic mul_vld_ff;
   coef_type coef_ff [9];

   logic [ANGLE_WIDTH-1:0] ang;
   logic signed [RED_W-1:0] v, r, t_full;
   logic [1:0] q;
   logic [T_W-1:0] t;
   logic [CORDIC_ZW-1:0] zt;
   trig_type c_val, s_val, a_op, b_op;
   logic signed [SUMW-1:0] sum, rnd;
   coef_type coef_in;

   // Reduce the selected angle to one turn and split off the quadrant
   always_comb begin
      case (sel_ff)
         2'd0:    ang = pitch_ff;
         2'd1:    ang = yaw_ff;
         default: ang = roll_ff;
      endcase
      v = {{(RED_W - ANGLE_WIDTH){ang[ANGLE_WIDTH-1]}}, ang};
      if (v < -FT) begin
         r = v + FT + FT;
      end else if (v < 0) begin
         r = v + FT;
      end else if (v >= FT) begin
         r = v - FT;
      end else begin
         r = v;
      end
      if (r >= QT + QT + QT) begin
         q = 2'd3;
         t_full = r - QT - QT - QT;
      end else if (r >= QT + QT) begin
         q = 2'd2;
         t_full = r - QT - QT;
      end else if (r >= QT) begin
         q = 2'd1;
         t_full = r - QT;
      end else begin
         q = 2'd0;
         t_full = r;
      end
      t  = t_full[T_W-1:0];
      zt = CORDIC_ZW'(t) << ANGLE_SHIFT;
   end

   // Map the first-quadrant result back to the full circle
   always_comb begin
      case (quad_ff)
         2'd0: begin
            c_val = TRIG_WIDTH'(x_ff);
            s_val = TRIG_WIDTH'(y_ff);
         end
         2'd1: begin
            c_val = TRIG_WIDTH'(-y_ff);
            s_val = TRIG_WIDTH'(x_ff);
         end
         2'd2: begin
            c_val = TRIG_WIDTH'(-x_ff);
            s_val = TRIG_WIDTH'(-y_ff);
         end
         default: begin
            c_val = TRIG_WIDTH'(y_ff);
            s_val = TRIG_WIDTH'(-x_ff);
         end
      endcase
   end

   // Operand select for the shared multiplier (cp sp cy sy cr sr = 0..5)
   always_comb begin
      case (step_ff)
         5'd0:    begin a_op = trig_ff[3]; b_op = trig_ff[1]; end
         5'd1:    begin a_op = trig_ff[2]; b_op = trig_ff[1]; end
         5'd2:    begin a_op = trig_ff[2]; b_op = trig_ff[4]; end
         5'd3:    begin a_op = trig_ff[2]; b_op = trig_ff[5]; end
         5'd4:    begin a_op = trig_ff[3]; b_op = trig_ff[0]; end
         5'd5:    begin a_op = trig_ff[0]; b_op = trig_ff[5]; end
         5'd6:    begin a_op = trig_ff[0]; b_op = trig_ff[4]; end
         5'd7:    begin a_op = trig_ff[3]; b_op = trig_ff[4]; end
         5'd8:    begin a_op = trig_ff[3]; b_op = trig_ff[5]; end
         5'd9:    begin a_op = trig_ff[2]; b_op = trig_ff[0]; end
         5'd10:   begin a_op = prod_ff[0]; b_op = trig_ff[5]; end
         5'd11:   begin a_op = prod_ff[0]; b_op = trig_ff[4]; end
         5'd12:   begin a_op = prod_ff[1]; b_op = trig_ff[5]; end
         default: begin a_op = prod_ff[1]; b_op = trig_ff[4]; end
      endcase
      mul_in = a_op * b_op;
   end

   // Combine products into one coefficient, round and clamp
   always_comb begin
      case (k_ff)
         4'd0:    sum = SUMW'(prod_ff[2]) + SUMW'(prod_ff[10]);
         4'd1:    sum = SUMW'(prod_ff[11]) - SUMW'(prod_ff[3]);
         4'd2:    sum = SUMW'(prod_ff[4]);
         4'd3:    sum = SUMW'(prod_ff[5]);
         4'd4:    sum = SUMW'(prod_ff[6]);
         4'd5:    sum = -SUMW'(trig_ff[1]);
         4'd6:    sum = SUMW'(prod_ff[12]) - SUMW'(prod_ff[7]);
         4'd7:    sum = SUMW'(prod_ff[8]) + SUMW'(prod_ff[13]);
         default: sum = SUMW'(prod_ff[9]);
      endcase
      rnd = (sum + CHALF) >>> CSHIFT;
      if (rnd > CMAX) begin
         coef_in = COEF_WIDTH'(CMAX);
      end else if (rnd < CMIN) begin
         coef_in = COEF_WIDTH'(CMIN);
      end else begin
         coef_in = COEF_WIDTH'(rnd);
      end
   end

   // Sequencer, CORDIC datapath and coefficient file
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pitch_ff   <= '0;
         yaw_ff     <= '0;
         roll_ff    <= '0;
         sel_ff     <= '0;
         step_ff    <= '0;
         k_ff       <= '0;
         mul_vld_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            coef_ff[i] <= (i % 4 == 0) ? coef_type'(1 << COEF_FRAC_BITS) : '0;
         end
      end else begin
         mul_vld_ff <= 1'b0;
         if (mul_vld_ff) begin
            prod_ff[mul_idx_ff] <= TRIG_WIDTH'((mul_ff + MUL_HALF) >>> TRIG_FRAC);
         end
         case (state_ff)
            ST_IDLE: begin
               if (csr_we) begin
                  case (csr_addr)
                     CSR_PITCH: begin pitch_ff <= csr_wdata; state_ff <= ST_SETUP; end
                     CSR_YAW:   begin yaw_ff <= csr_wdata;   state_ff <= ST_SETUP; end
                     CSR_ROLL:  begin roll_ff <= csr_wdata;  state_ff <= ST_SETUP; end
                     default:   ;
                  endcase
                  sel_ff <= '0;
               end
            end
            ST_SETUP: begin
               quad_ff <= q;
               step_ff <= '0;
               if (t == '0) begin
                  x_ff     <= CORDIC_XW'(64'sd1 <<< TRIG_FRAC);
                  y_ff     <= '0;
                  state_ff <= ST_FINISH;
               end else begin
                  x_ff     <= CORDIC_XW'(CORDIC_START);
                  y_ff     <= '0;
                  z_ff     <= signed'(zt);
                  state_ff <= ST_ROTATE;
               end
            end
            ST_ROTATE: begin
               if (!z_ff[CORDIC_ZW-1]) begin
                  x_ff <= x_ff - (y_ff >>> step_ff);
                  y_ff <= y_ff + (x_ff >>> step_ff);
                  z_ff <= z_ff - atan_unit(step_ff);
               end else begin
                  x_ff <= x_ff + (y_ff >>> step_ff);
                  y_ff <= y_ff - (x_ff >>> step_ff);
                  z_ff <= z_ff + atan_unit(step_ff);
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               trig_ff[{sel_ff, 1'b0}] <= c_val;
               trig_ff[{sel_ff, 1'b1}] <= s_val;
               step_ff <= '0;
               if (sel_ff == 2'd2) begin
                  state_ff <= ST_MULT;
               end else begin
                  sel_ff   <= sel_ff + 1'b1;
                  state_ff <= ST_SETUP;
               end
            end
            ST_MULT: begin
               mul_ff     <= mul_in;
               mul_idx_ff <= step_ff[3:0];
               mul_vld_ff <= 1'b1;
               step_ff    <= step_ff + 1'b1;
               if (step_ff == 5'd13) begin
                  k_ff     <= '0;
                  state_ff <= ST_STORE;
               end
            end
            ST_STORE: begin
               coef_ff[k_ff] <= coef_in;
               k_ff <= k_ff + 1'b1;
               if (k_ff == 4'd8) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign coef = coef_ff;

endmodule

// ===== hdl/euler_vertex_rotator_top.sv =====
// ----------------------------------------------------------------------------
// euler_vertex_rotator_top
// Rotates a stream of Q16.16 vertices by a matrix built from three angles.
// ----------------------------------------------------------------------------
// Takes one vertex word per cycle while req_tready is high and returns it
// rotated through the input register, the nine 18x32 multipliers, the adder
// stage and the round and clamp stage. After a write to pitch, yaw or roll
// the block rebuilds its matrix and holds req_tready low meanwhile: a
// 20-step CORDIC per angle (skipped on exact multiples of 90 degrees), the
// trig products on the shared multiplier, then storing the nine coefficients.
// Components beyond the Q16.16 range clamp and set rsp_tuser.
module euler_vertex_rotator_top import evr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_WIDTH-1:0]  req_tdata,  // in_x, in_y, in_z
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DATA_WIDTH-1:0]  rsp_tdata,  // out_x, out_y, out_z
   output logic                   rsp_tlast,
   output logic                   rsp_tuser,  // saturated
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [ANGLE_WIDTH-1:0] csr_wdata
);

`include "assert_macros.svh"

   localparam int PW = COEF_WIDTH + COORD_WIDTH;
   localparam int SW = PW + 2;
   localparam logic signed [PW:0] HALF = (PW + 1)'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [SW-1:0] HI = {{(SW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
   localparam logic signed [SW-1:0] LO = {{(SW - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

   coef_type coef [9];
   logic busy, advance, accept;

   coord_type vin_ff [3];
   logic vld_a_ff, last_a_ff;
   logic signed [PW-1:0] prod_ff [9];
   logic vld_b_ff, last_b_ff;
   logic signed [PW:0] s01_ff [3], s2h_ff [3];
   logic vld_c_ff, last_c_ff;
   coord_type res_ff [3];
   logic sat_ff, last_ff, vld_ff;

   logic signed [SW-1:0] tot [3];
   coord_type res_in [3];
   logic [2:0] clip;

   evr_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .coef      (coef),
      .busy      (busy)
   );

   // Advance the whole pipeline unless the output word is stalled
   assign advance    = !vld_ff || rsp_tready;
   assign req_tready = advance && !busy;
   assign accept     = req_tvalid && req_tready;

   // Round, shift and clamp each row sum
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         tot[r] = (SW'(s01_ff[r]) + SW'(s2h_ff[r])) >>> COEF_FRAC_BITS;
         if (tot[r] > HI) begin
            res_in[r] = COORD_WIDTH'(HI);
            clip[r]   = 1'b1;
         end else if (tot[r] < LO) begin
            res_in[r] = COORD_WIDTH'(LO);
            clip[r]   = 1'b1;
         end else begin
            res_in[r] = COORD_WIDTH'(tot[r]);
            clip[r]   = 1'b0;
         end
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
         vld_ff   <= 1'b0;
      end else if (advance) begin
         vld_a_ff <= accept;
         vld_b_ff <= vld_a_ff;
         vld_c_ff <= vld_b_ff;
         vld_ff   <= vld_c_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         vin_ff[0] <= req_tdata[COORD_WIDTH-1:0];
         vin_ff[1] <= req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
         vin_ff[2] <= req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
         last_a_ff <= req_tlast;
         for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[r*3+j] <= PW'(coef[r*3+j]) * PW'(vin_ff[j]);
            end
         end
         last_b_ff <= last_a_ff;
         for (int r = 0; r < 3; r++) begin
            s01_ff[r] <= (PW + 1)'(prod_ff[r*3]) + (PW + 1)'(prod_ff[r*3+1]);
            s2h_ff[r] <= (PW + 1)'(prod_ff[r*3+2]) + HALF;
         end
         last_c_ff <= last_b_ff;
         res_ff    <= res_in;
         sat_ff    <= |clip;
         last_ff   <= last_c_ff;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = DATA_WIDTH'({res_ff[2], res_ff[1], res_ff[0]});
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = sat_ff;

   `ASSERT_ALWAYS(a_no_accept_busy, clock, reset, !(req_tready && busy), "input taken while matrix rebuilds")
   `ASSERT_NEXT(a_stage_fill, clock, reset, vld_c_ff && advance, rsp_tvalid, "word lost before output")
   `ASSERT_ALWAYS(a_sat_extreme, clock, reset, !(rsp_tvalid && rsp_tuser) || res_ff[0] == COORD_WIDTH'(HI) || res_ff[0] == COORD_WIDTH'(LO) || res_ff[1] == COORD_WIDTH'(HI) || res_ff[1] == COORD_WIDTH'(LO) || res_ff[2] == COORD_WIDTH'(HI) || res_ff[2] == COORD_WIDTH'(LO), "saturation flag without clamped component")

endmodule

// ===== tb/sv/rotation_checker.sv =====
// ----------------------------------------------------------------------------
// rotation_checker
// Watches the register port and both streams of the rotator, predicts each
// rotated vertex from its own copy of the angles and matrix, and compares.
// ----------------------------------------------------------------------------
module rotation_checker import evr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [DATA_WIDTH-1:0]  req_tdata,  // in_x, in_y, in_z
   input  logic                   req_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [DATA_WIDTH-1:0]  rsp_tdata,  // out_x, out_y, out_z
   input  logic                   rsp_tlast,
   input  logic                   rsp_tuser,  // saturated
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [ANGLE_WIDTH-1:0] csr_wdata,
   output int                     mismatches,
   output int                     outstanding
);

   typedef struct {
      logic [COORD_WIDTH-1:0] x;
      logic [COORD_WIDTH-1:0] y;
      logic [COORD_WIDTH-1:0] z;
      logic                   last;
      logic                   sat;
   } vertex_word_type;

   // Arctangent of 2^-i in 2^-20 degree units
   localparam longint ATAN_TBL [CORDIC_STEPS] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
      469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115};

   vertex_word_type        rotated_q[$];
   logic [ANGLE_WIDTH-1:0] angle_reg [3];
   longint                 matrix [9];

   assign outstanding = rotated_q.size();

   initial mismatches = 0;

   // Cosine and sine in Q2.30 of an angle in 1/64 degree
   function automatic void angle_sincos(input logic [ANGLE_WIDTH-1:0] raw,
                                        output longint c, output longint s);
      longint r, t, x, y, z, nx;
      int     q;
      r = longint'($signed(raw)) % FULL_TURN;
      if (r < 0) r += FULL_TURN;
      q = int'(r / QUARTER_TURN);
      t = r % QUARTER_TURN;
      x = longint'(1) << TRIG_FRAC;
      y = 0;
      if (t != 0) begin
         x = CORDIC_START;
         z = t << ANGLE_SHIFT;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y  = y + (x >>> i);
               z -= ATAN_TBL[i];
            end else begin
               nx = x + (y >>> i);
               y  = y - (x >>> i);
               z += ATAN_TBL[i];
            end
            x = nx;
         end
      end
      case (q)
         0:       begin c = x;  s = y;  end
         1:       begin c = -y; s = x;  end
         2:       begin c = -x; s = -y; end
         default: begin c = y;  s = -x; end
      endcase
   endfunction

   // Product of two Q2.30 values, rounded half up
   function automatic longint trig_prod(input longint a, input longint b);
      return (a * b + (longint'(1) << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
   endfunction

   // Round Q2.30 to coefficient format and clamp
   function automatic longint quantize(input longint v);
      longint lim;
      int     sh;
      lim = longint'(1) << (COEF_FRAC_BITS + 1);
      sh  = TRIG_FRAC - COEF_FRAC_BITS;
      v = (v + (longint'(1) << (sh - 1))) >>> sh;
      if (v > lim - 1) v = lim - 1;
      if (v < -lim) v = -lim;
      return v;
   endfunction

   function automatic void rebuild_matrix();
      longint cp, sp, cy, sy, cr, sr, ysp, ycp;
      angle_sincos(angle_reg[0], cp, sp);
      angle_sincos(angle_reg[1], cy, sy);
      angle_sincos(angle_reg[2], cr, sr);
      ysp = trig_prod(sy, sp);
      ycp = trig_prod(cy, sp);
      matrix[0] = quantize(trig_prod(cy, cr) + trig_prod(ysp, sr));
      matrix[1] = quantize(-trig_prod(cy, sr) + trig_prod(ysp, cr));
      matrix[2] = quantize(trig_prod(sy, cp));
      matrix[3] = quantize(trig_prod(cp, sr));
      matrix[4] = quantize(trig_prod(cp, cr));
      matrix[5] = quantize(-sp);
      matrix[6] = quantize(-trig_prod(sy, cr) + trig_prod(ycp, sr));
      matrix[7] = quantize(trig_prod(sy, sr) + trig_prod(ycp, cr));
      matrix[8] = quantize(trig_prod(cy, cp));
   endfunction

   // Rotate one vertex word, clamping each component
   function automatic vertex_word_type rotate_vertex(input logic [DATA_WIDTH-1:0] d,
                                                     input logic last);
      vertex_word_type w;
      longint hi_part [3];
      longint lo_part [3];
      longint v, a, b, res, hi, lo;
      logic [COORD_WIDTH-1:0] comp [3];
      hi = (longint'(1) << (COORD_WIDTH - 1)) - 1;
      lo = -hi - 1;
      w.sat = 1'b0;
      for (int j = 0; j < 3; j++) begin
         v = longint'($signed(d[j*COORD_WIDTH +: COORD_WIDTH]));
         hi_part[j] = v >>> COEF_FRAC_BITS;
         lo_part[j] = v - (hi_part[j] << COEF_FRAC_BITS);
      end
      for (int r = 0; r < 3; r++) begin
         a = 0;
         b = 0;
         for (int j = 0; j < 3; j++) begin
            a += matrix[r*3 + j] * hi_part[j];
            b += matrix[r*3 + j] * lo_part[j];
         end
         res = a + ((b + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS);
         if (res > hi) begin
            res = hi;
            w.sat = 1'b1;
         end else if (res < lo) begin
            res = lo;
            w.sat = 1'b1;
         end
         comp[r] = res[COORD_WIDTH-1:0];
      end
      w.x = comp[0];
      w.y = comp[1];
      w.z = comp[2];
      w.last = last;
      return w;
   endfunction

   // Track registers, queue predictions, compare results
   always @(posedge clock) begin
      vertex_word_type exp_w;
      if (reset) begin
         rotated_q.delete();
         for (int i = 0; i < 3; i++) angle_reg[i] = '0;
         for (int i = 0; i < 9; i++) matrix[i] = (i % 4 == 0) ? (longint'(1) << COEF_FRAC_BITS) : 0;
      end else begin
         if (csr_we && (csr_addr == CSR_PITCH || csr_addr == CSR_YAW || csr_addr == CSR_ROLL)) begin
            angle_reg[csr_addr] = csr_wdata;
            rebuild_matrix();
         end
         if (req_tvalid && req_tready)
            rotated_q.push_back(rotate_vertex(req_tdata, req_tlast));
         if (rsp_tvalid && rsp_tready) begin
            if (rotated_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word %h last=%b sat=%b",
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               exp_w = rotated_q.pop_front();
               if (rsp_tdata[0 +: COORD_WIDTH] !== exp_w.x ||
                   rsp_tdata[COORD_WIDTH +: COORD_WIDTH] !== exp_w.y ||
                   rsp_tdata[2*COORD_WIDTH +: COORD_WIDTH] !== exp_w.z ||
                   rsp_tlast !== exp_w.last || rsp_tuser !== exp_w.sat) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp x=%h y=%h z=%h last=%b sat=%b, got x=%h y=%h z=%h last=%b sat=%b",
                              exp_w.x, exp_w.y, exp_w.z, exp_w.last, exp_w.sat,
                              rsp_tdata[0 +: COORD_WIDTH],
                              rsp_tdata[COORD_WIDTH +: COORD_WIDTH],
                              rsp_tdata[2*COORD_WIDTH +: COORD_WIDTH],
                              rsp_tlast, rsp_tuser);
               end
            end
         end
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the Euler vertex rotator: directed angles and vertices, then
// random angle settings with random vertex streams under varied back-pressure.
// ----------------------------------------------------------------------------
module tb;
   import evr_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [DATA_WIDTH-1:0]  req_tdata = '0;  // in_x, in_y, in_z
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [DATA_WIDTH-1:0]  rsp_tdata;       // out_x, out_y, out_z
   logic                   rsp_tlast;
   logic                   rsp_tuser;       // saturated
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [ANGLE_WIDTH-1:0] csr_wdata = '0;

   int mismatches;
   int outstanding;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int idle_cycles    = 0;
   int sent_words     = 0;
   int csr_count      = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   euler_vertex_rotator_top uut (.*);

   rotation_checker chk (.*);

   // Randomly stall the result stream
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Hold valid until the word is taken
   task automatic send_vertex(input logic [COORD_WIDTH-1:0] x, input logic [COORD_WIDTH-1:0] y,
                              input logic [COORD_WIDTH-1:0] z, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sent_words++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write one angle register once the pipe is empty, then wait out the rebuild
   task automatic write_angle(input logic [CSR_ADDR_W-1:0] idx, input logic [ANGLE_WIDTH-1:0] val);
      drain();
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      repeat (3) @(posedge clock);
      while (!req_tready) @(posedge clock);
      csr_count++;
   endtask

   task automatic set_angles(input logic [15:0] p, input logic [15:0] yw, input logic [15:0] r);
      write_angle(CSR_PITCH, p);
      write_angle(CSR_YAW, yw);
      write_angle(CSR_ROLL, r);
   endtask

   function automatic logic [COORD_WIDTH-1:0] rand_coord();
      case ($urandom_range(3))
         0:       return $urandom;
         1:       return {{8{1'($urandom_range(1))}}, 24'($urandom)};
         2:       return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3) :
                                              32'h8000_0000 + $urandom_range(3);
         default: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
      endcase
   endfunction

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(3))
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(4)) * 16'(QUARTER_TURN);
         2:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         default: return 16'($signed(17'($urandom_range(2 * FULL_TURN)) - 17'(FULL_TURN)));
      endcase
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Identity after reset: extremes pass unchanged
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
      send_vertex(32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000, 1'b1);
      // Quarter turns: exact swaps, and an ignored write to the spare index
      set_angles(16'd5760, 16'd0, 16'd0);
      write_angle(2'd3, 16'h1234);
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0002_8000, 1'b0);
      set_angles(16'd0, 16'hE980, 16'd11520);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
      send_vertex(32'h0003_0000, 32'hFFFC_0000, 32'h0000_8000, 1'b0);
      // Full turn reduces to zero; extremes of the angle range
      set_angles(16'd23040, 16'h7FFF, 16'h8000);
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      // Forty-five degrees on every axis: large inputs saturate
      set_angles(16'd2880, 16'd2880, 16'd2880);
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
      send_vertex(32'h0001_2345, 32'hFFFE_DCBA, 32'h0000_7FFF, 1'b0);
      send_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 1'b1);

      // Random angle settings, four idling styles in turn
      for (int phase = 0; phase < 8; phase++) begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
         set_angles(rand_angle(), rand_angle(), rand_angle());
         case (phase % 4)
            1: send_idle_pct = 47;
            2: recv_stall_pct = 47;
            3: begin
               send_idle_pct  = 13;
               recv_stall_pct = 13;
            end
            default: ;
         endcase
         for (int n = 0; n < 230; n++) begin
            if (n == 115 && phase == 2) drain();
            send_vertex(rand_coord(), rand_coord(), rand_coord(), $urandom_range(7) == 0);
         end
      end

      drain();
      repeat (10) @(posedge clock);
      $display("Sent %0d vertices across %0d register writes, quarter turns, range extremes",
               sent_words, csr_count);
      $display("and saturating inputs under sender gaps and receiver stalls.");
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
